[design/qau_pkg.sv]
// Package for the quaternion arithmetic unit: constants, codes, types and helper functions.
`default_nettype none

package qau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB        = FRAC_BITS + 1;   // quotient bits of a normalize division
  localparam int DW        = 32 + FRAC_BITS;  // dividend width
  localparam int SQ_STEPS  = 32;              // root bits of the 64-bit square root

  localparam logic [2:0] OP_PRODUCT = 3'd0;
  localparam logic [2:0] OP_VECTOR  = 3'd1;
  localparam logic [2:0] OP_SCALE   = 3'd2;
  localparam logic [2:0] OP_CONJ    = 3'd3;
  localparam logic [2:0] OP_NORM    = 3'd4;
  localparam logic [2:0] OP_LENGTH  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]       op;
    logic [3:0][31:0] r;
    logic [30:0]      lsq;
    logic [1:0]       status;
    logic [3:0]       neg;
    logic [3:0][31:0] mag;
    logic             zero;
    logic             big;
  } qau_carry_t;

  function automatic logic [63:0] smul(input logic [31:0] u, input logic [31:0] v);
    logic signed [63:0] p;
    p = $signed(u) * $signed(v);
    return p;
  endfunction

  function automatic logic [64:0] sx65(input logic [63:0] p);
    return {p[63], p};
  endfunction

  // round to nearest, ties up, then saturate to signed 32; msb is the saturation flag
  function automatic logic [32:0] rnd_sat(input logic [65:0] v);
    logic [65:0] t;
    logic [65:0] q;
    t = v + (66'd1 << (FRAC_BITS - 1));
    q = 66'($signed(t) >>> FRAC_BITS);
    if (q[65:31] == '0 || q[65:31] == '1) begin
      return {1'b0, q[31:0]};
    end else if (q[65]) begin
      return {1'b1, S32_MIN};
    end
    return {1'b1, S32_MAX};
  endfunction

  function automatic logic [31:0] lsq_rnd(input logic [64:0] s);
    logic [65:0] t;
    logic [65:0] q;
    t = {1'b0, s} + (66'd1 << (FRAC_BITS - 1));
    q = t >> FRAC_BITS;
    if (q[65:31] != '0) begin
      return {1'b1, S32_MAX[30:0]};
    end
    return {1'b0, q[30:0]};
  endfunction

endpackage

`default_nettype wire

[design/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit: Q16.16 product, scale, conjugate, normalize and length, pipelined.
//
//  channel  | dir | tdata fields (low bit up)                        | tuser
//  s_*      | in  | a_x a_y a_z a_w b_x b_y b_z b_w                  | opcode
//  m_*      | out | r_x r_y r_z r_w length_sq, one pad bit           | status
//
// One item enters per cycle unless a stall at m_tready holds the pipe; the stages in order are
// 4 product/sum/round stages, 32 square-root stages (one root bit each),
// 1 dividend setup stage, QB restoring-division stages (one quotient bit each), 1 output register.
// rst clears the valid bits only. A stall at m_tready freezes every stage together.
`default_nettype none

module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  logic [2:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // r_x, r_y, r_z, r_w, length_sq, zero pad
  output logic [1:0]   m_tuser    // status
);

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---------------- stage 1: products ----------------
  logic [3:0][31:0] in_a, in_b;
  logic [31:0] bx, by, bz, bw;
  logic [3:0][3:0][63:0] prod;
  logic [3:0][63:0] sqr;

  assign in_a = s_tdata[127:0];
  assign in_b = s_tdata[255:128];

  always_comb begin
    bx = (s_tuser == OP_SCALE) ? '0 : in_b[0];
    by = (s_tuser == OP_SCALE) ? '0 : in_b[1];
    bz = (s_tuser == OP_SCALE) ? '0 : in_b[2];
    bw = (s_tuser == OP_VECTOR) ? '0 : in_b[3];
    prod[0][0] = smul(in_a[0], bw); prod[0][1] = smul(in_a[3], bx);
    prod[0][2] = smul(in_a[1], bz); prod[0][3] = smul(in_a[2], by);
    prod[1][0] = smul(in_a[1], bw); prod[1][1] = smul(in_a[3], by);
    prod[1][2] = smul(in_a[2], bx); prod[1][3] = smul(in_a[0], bz);
    prod[2][0] = smul(in_a[2], bw); prod[2][1] = smul(in_a[3], bz);
    prod[2][2] = smul(in_a[0], by); prod[2][3] = smul(in_a[1], bx);
    prod[3][0] = smul(in_a[3], bw); prod[3][1] = smul(in_a[0], bx);
    prod[3][2] = smul(in_a[1], by); prod[3][3] = smul(in_a[2], bz);
    for (int i = 0; i < 4; i++) begin
      sqr[i] = smul(in_a[i], in_a[i]);
    end
  end

  logic                  p1_v;
  logic [2:0]            p1_op;
  logic [3:0][31:0]      p1_a;
  logic [3:0][3:0][63:0] p1_prod;
  logic [3:0][63:0]      p1_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (adv) begin
      p1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_op   <= s_tuser;
      p1_a    <= in_a;
      p1_prod <= prod;
      p1_sq   <= sqr;
    end
  end

  // ---------------- stage 2: pair sums ----------------
  logic [3:0][1:0][64:0] pair;
  logic [1:0][64:0]      sqp;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pair[c][0] = sx65(p1_prod[c][0]) + sx65(p1_prod[c][1]);
      pair[c][1] = sx65(p1_prod[c][2]) - sx65(p1_prod[c][3]);
    end
    pair[3][0] = sx65(p1_prod[3][0]) - sx65(p1_prod[3][1]);
    pair[3][1] = 65'd0 - sx65(p1_prod[3][2]) - sx65(p1_prod[3][3]);
    sqp[0] = {1'b0, p1_sq[0]} + {1'b0, p1_sq[1]};
    sqp[1] = {1'b0, p1_sq[2]} + {1'b0, p1_sq[3]};
  end

  logic                  p2_v;
  logic [2:0]            p2_op;
  logic [3:0][31:0]      p2_a;
  logic [3:0][1:0][64:0] p2_pair;
  logic [1:0][64:0]      p2_sqp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (adv) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_op   <= p1_op;
      p2_a    <= p1_a;
      p2_pair <= pair;
      p2_sqp  <= sqp;
    end
  end

  // ---------------- stage 3: full sums ----------------
  logic                  p3_v;
  logic [2:0]            p3_op;
  logic [3:0][31:0]      p3_a;
  logic [3:0][65:0]      p3_acc;
  logic [64:0]           p3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (adv) begin
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_op <= p2_op;
      p3_a  <= p2_a;
      for (int c = 0; c < 4; c++) begin
        p3_acc[c] <= {p2_pair[c][0][64], p2_pair[c][0]} + {p2_pair[c][1][64], p2_pair[c][1]};
      end
      p3_s <= p2_sqp[0] + p2_sqp[1];
    end
  end

  // ---------------- stage 4: round, saturate, select ----------------
  qau_carry_t c4;
  logic [31:0] lr;
  logic [32:0] rs;
  logic        sat;

  always_comb begin
    c4     = '0;
    sat    = 1'b0;
    rs     = '0;
    lr     = lsq_rnd(p3_s);
    c4.op  = p3_op;
    c4.lsq = lr[30:0];
    c4.r   = p3_a;
    for (int i = 0; i < 4; i++) begin
      c4.neg[i] = p3_a[i][31];
      c4.mag[i] = p3_a[i][31] ? 32'd0 - p3_a[i] : p3_a[i];
    end
    c4.zero   = (p3_s == '0);
    c4.big    = p3_s[64];
    c4.status = ST_OK;
    case (p3_op) inside
      OP_PRODUCT, OP_VECTOR, OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          rs       = rnd_sat(p3_acc[i]);
          c4.r[i]  = rs[31:0];
          sat      = sat | rs[32];
        end
        c4.status = sat ? ST_SAT : ST_OK;
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          if (p3_a[i] == S32_MIN) begin
            c4.r[i] = S32_MAX;
            sat     = 1'b1;
          end else begin
            c4.r[i] = 32'd0 - p3_a[i];
          end
        end
        c4.status = sat ? ST_SAT : ST_OK;
      end
      OP_LENGTH: begin
        c4.r      = '0;
        c4.status = lr[31] ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  logic        p4_v;
  qau_carry_t  p4_c;
  logic [63:0] p4_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (adv) begin
      p4_v <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_c <= c4;
      p4_n <= p3_s[63:0];
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic        sq_v    [SQ_STEPS];
  qau_carry_t  sq_c    [SQ_STEPS];
  logic [63:0] sq_n    [SQ_STEPS];
  logic [32:0] sq_rem  [SQ_STEPS];
  logic [31:0] sq_root [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic        v_in;
    qau_carry_t  c_in;
    logic [63:0] n_in;
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [34:0] trial, sub;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in    = p4_v;
      assign c_in    = p4_c;
      assign n_in    = p4_n;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_v[k-1];
      assign c_in    = sq_c[k-1];
      assign n_in    = sq_n[k-1];
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
    end

    assign trial = {rem_in, n_in[63-2*k -: 2]};
    assign sub   = {1'b0, root_in, 2'b01};
    assign ge    = (trial >= sub);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (adv) begin
        sq_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k]    <= c_in;
        sq_n[k]    <= n_in;
        sq_rem[k]  <= ge ? 33'(trial - sub) : trial[32:0];
        sq_root[k] <= {root_in[30:0], ge};
      end
    end
  end

  // ---------------- dividend setup ----------------
  logic [32:0]          len;
  logic [3:0][DW-1:0]   dvd;
  logic [3:0][32:0]     rem0;

  always_comb begin
    len = sq_c[SQ_STEPS-1].big ? {1'b1, 32'd0} : {1'b0, sq_root[SQ_STEPS-1]};
    for (int l = 0; l < 4; l++) begin
      dvd[l]  = {sq_c[SQ_STEPS-1].mag[l], {FRAC_BITS{1'b0}}} + DW'(len[32:1]);
      rem0[l] = 33'(dvd[l][DW-1:QB]);
    end
  end

  logic               ds_v;
  qau_carry_t         ds_c;
  logic [32:0]        ds_len;
  logic [3:0][DW-1:0] ds_d;
  logic [3:0][32:0]   ds_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_v <= 1'b0;
    end else if (adv) begin
      ds_v <= sq_v[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_c   <= sq_c[SQ_STEPS-1];
      ds_len <= len;
      ds_d   <= dvd;
      ds_rem <= rem0;
    end
  end

  // ---------------- division, one quotient bit per stage, four lanes ----------------
  logic               dv_v   [QB];
  qau_carry_t         dv_c   [QB];
  logic [32:0]        dv_len [QB];
  logic [3:0][DW-1:0] dv_d   [QB];
  logic [3:0][32:0]   dv_rem [QB];
  logic [3:0][QB-1:0] dv_q   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_dv
    logic               v_in;
    qau_carry_t         c_in;
    logic [32:0]        len_in;
    logic [3:0][DW-1:0] d_in;
    logic [3:0][32:0]   rem_in;
    logic [3:0][QB-1:0] q_in;
    logic [3:0][32:0]   rem_nx;
    logic [3:0][QB-1:0] q_nx;
    logic [33:0]        r2;
    logic               ge;

    if (k == 0) begin : g_first
      assign v_in   = ds_v;
      assign c_in   = ds_c;
      assign len_in = ds_len;
      assign d_in   = ds_d;
      assign rem_in = ds_rem;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = dv_v[k-1];
      assign c_in   = dv_c[k-1];
      assign len_in = dv_len[k-1];
      assign d_in   = dv_d[k-1];
      assign rem_in = dv_rem[k-1];
      assign q_in   = dv_q[k-1];
    end

    always_comb begin
      r2 = '0;
      ge = 1'b0;
      for (int l = 0; l < 4; l++) begin
        r2        = {rem_in[l], d_in[l][QB-1-k]};
        ge        = (r2 >= {1'b0, len_in});
        rem_nx[l] = ge ? 33'(r2 - {1'b0, len_in}) : r2[32:0];
        q_nx[l]   = {q_in[l][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (adv) begin
        dv_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[k]   <= c_in;
        dv_len[k] <= len_in;
        dv_d[k]   <= d_in;
        dv_rem[k] <= rem_nx;
        dv_q[k]   <= q_nx;
      end
    end
  end

  // ---------------- output register ----------------
  qau_carry_t       cf;
  logic [3:0][31:0] fin_r;
  logic [1:0]       fin_st;
  logic [31:0]      qq;

  always_comb begin
    cf     = dv_c[QB-1];
    fin_r  = cf.r;
    fin_st = cf.status;
    qq     = '0;
    if (cf.op == OP_NORM) begin
      if (cf.zero) begin
        fin_r  = '0;
        fin_st = ST_ZERO;
      end else begin
        for (int l = 0; l < 4; l++) begin
          qq       = 32'(dv_q[QB-1][l]);
          fin_r[l] = cf.neg[l] ? 32'd0 - qq : qq;
        end
      end
    end
  end

  logic [3:0][31:0] out_r;
  logic [30:0]      out_lsq;
  logic [1:0]       out_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_v[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r   <= fin_r;
      out_lsq <= cf.lsq;
      out_st  <= fin_st;
    end
  end

  assign m_tdata = {1'b0, out_lsq, out_r};
  assign m_tuser = out_st;

  // ---------------- assertions ----------------
  a_zero_len_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ZERO |-> m_tdata[127:0] == '0)
    else $error("zero-length normalize returned nonzero components");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ_STEPS-1] && !sq_c[SQ_STEPS-1].big |->
      (66'(sq_root[SQ_STEPS-1]) * 66'(sq_root[SQ_STEPS-1]) <= 66'(sq_n[SQ_STEPS-1])) &&
      ((66'(sq_root[SQ_STEPS-1]) + 66'd1) * (66'(sq_root[SQ_STEPS-1]) + 66'd1)
        > 66'(sq_n[SQ_STEPS-1])))
    else $error("square root stage result is not the floor root");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    dv_v[QB-1] && dv_c[QB-1].op == OP_NORM && !dv_c[QB-1].zero |->
      dv_q[QB-1][0] <= (QB'(1) << FRAC_BITS) && dv_q[QB-1][1] <= (QB'(1) << FRAC_BITS) &&
      dv_q[QB-1][2] <= (QB'(1) << FRAC_BITS) && dv_q[QB-1][3] <= (QB'(1) << FRAC_BITS))
    else $error("normalized component exceeds one");

  a_len_status: assert property (@(posedge clk) disable iff (rst)
    p4_v && p4_c.op == OP_LENGTH |-> p4_c.r == '0 &&
      (p4_c.status == ST_OK || p4_c.status == ST_SAT))
    else $error("length-only item carries a nonzero quaternion");

endmodule

`default_nettype wire

[dv/quaternion_arithmetic_unit_tb.sv]
// Testbench for the quaternion arithmetic unit: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module quaternion_arithmetic_unit_tb;
  import qau_pkg::*;

  typedef struct {
    logic [3:0][31:0] r;
    logic [30:0]      lsq;
    logic [1:0]       status;
  } quat_result_t;

  class quat_scoreboard;
    quat_result_t pending[$];
    int           errors;

    // exact sum rounded at FRAC_BITS, ties up, saturated to [mn, mx]
    function automatic logic [31:0] round_sat(logic signed [71:0] v, longint mn, longint mx,
                                              ref bit sat);
      logic signed [71:0] q;
      q = (v + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > mx) begin
        sat = 1;
        return mx[31:0];
      end
      if (q < mn) begin
        sat = 1;
        return mn[31:0];
      end
      return q[31:0];
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_item(logic [2:0] op, logic [255:0] d);
      quat_result_t e;
      logic signed [71:0] a[4], b[4], s, acc[4];
      logic [71:0] len, mag, q;
      bit sat, lsat;
      for (int i = 0; i < 4; i++) begin
        a[i] = $signed(d[32*i +: 32]);
        b[i] = $signed(d[128 + 32*i +: 32]);
      end
      sat = 0;
      lsat = 0;
      s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
      e.lsq = 31'(round_sat(s, 0, 64'h7fffffff, lsat));
      for (int i = 0; i < 4; i++) e.r[i] = a[i][31:0];
      e.status = ST_OK;
      case (op)
        OP_PRODUCT, OP_VECTOR: begin
          if (op == OP_VECTOR) b[3] = 0;
          acc[0] = a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1];
          acc[1] = a[1]*b[3] + a[3]*b[1] + a[2]*b[0] - a[0]*b[2];
          acc[2] = a[2]*b[3] + a[3]*b[2] + a[0]*b[1] - a[1]*b[0];
          acc[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
          for (int i = 0; i < 4; i++)
            e.r[i] = round_sat(acc[i], -64'sh80000000, 64'h7fffffff, sat);
          e.status = sat ? ST_SAT : ST_OK;
        end
        OP_SCALE: begin
          for (int i = 0; i < 4; i++)
            e.r[i] = round_sat(a[i]*b[3], -64'sh80000000, 64'h7fffffff, sat);
          e.status = sat ? ST_SAT : ST_OK;
        end
        OP_CONJ: begin
          for (int i = 0; i < 3; i++) begin
            if (a[i][31:0] == S32_MIN) begin
              e.r[i] = S32_MAX;
              sat = 1;
            end else begin
              e.r[i] = 32'(-a[i]);
            end
          end
          e.status = sat ? ST_SAT : ST_OK;
        end
        OP_NORM: begin
          if (s == 0) begin
            e.status = ST_ZERO;
          end else begin
            len = (s[71:64] != 0) ? 72'd1 << 32 : 72'(root64(s[63:0]));
            for (int i = 0; i < 4; i++) begin
              mag = a[i] < 0 ? -a[i] : a[i];
              q = ((mag << FRAC_BITS) + (len >> 1)) / len;
              e.r[i] = a[i] < 0 ? 32'(-q) : q[31:0];
            end
          end
        end
        OP_LENGTH: begin
          e.r = '0;
          e.status = lsat ? ST_SAT : ST_OK;
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(logic [159:0] d, logic [1:0] st);
      quat_result_t e;
      if (pending.size() == 0) begin
        report("unexpected item", d[31:0], 0);
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (d[32*i +: 32] !== e.r[i]) report($sformatf("r[%0d]", i), d[32*i +: 32], e.r[i]);
      if (d[158:128] !== e.lsq) report("length_sq", 32'(d[158:128]), 32'(e.lsq));
      if (st !== e.status) report("status", 32'(st), 32'(e.status));
    endtask
  endclass

  logic         clk = 0, rst = 1;
  logic         s_tvalid = 0, m_tready = 0;
  logic         s_tready, m_tvalid;
  logic [255:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic [159:0] m_tdata;
  logic [1:0]   m_tuser;
  quat_scoreboard sb = new();
  longint cycles = 0;
  bit     steady = 0;

  quaternion_arithmetic_unit dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(negedge clk) m_tready <= steady || ($urandom_range(99) >= 27);

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 0;
      3: return 32'($signed($urandom_range(8)) - 4) << 16;
      4: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // entered at a falling edge; leaves at a falling edge with s_tvalid still high
  task send_item(logic [2:0] op, logic [255:0] d);
    while (!steady && $urandom_range(99) < 27) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, d);
    @(negedge clk);
  endtask

  initial begin
    logic [255:0] d;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int op = 0; op < 8; op++) begin
      send_item(3'(op), '0);
      send_item(3'(op), {8{S32_MIN}});
      send_item(3'(op), {8{S32_MAX}});
    end
    send_item(OP_NORM, {224'd0, 32'h0001_0000});
    for (int n = 0; n < 750; n++) begin
      steady = (n >= 300 && n < 420);
      for (int i = 0; i < 8; i++) d[32*i +: 32] = pick_value();
      send_item(3'($urandom_range(9) > 7 ? $urandom_range(7, 6) : $urandom_range(5)), d);
    end
    s_tvalid <= 0;
    steady = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
